@@ sv/afp_pkg.sv @@
package afp_pkg;

	// Field widths of the channels
	localparam int unsigned WordW    = 32;
	localparam int unsigned ByteW    = 8;
	localparam int unsigned FrameW   = 15;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 15;

	// Byte burst produced by one item: up to twelve bytes, left aligned
	localparam int unsigned BurstBytes = 12;
	localparam int unsigned BurstW     = BurstBytes * ByteW;
	localparam int unsigned BurstCntW  = 4;

	// Bits left over in the partial byte while a frame is open
	localparam int unsigned PendW = 7;

	// Bytes per item: first item of a frame carries the header, last one the footer
	localparam logic [BurstCntW-1:0] CntMid       = 4'd4;
	localparam logic [BurstCntW-1:0] CntLast      = 4'd6;
	localparam logic [BurstCntW-1:0] CntFirst     = 4'd10;
	localparam logic [BurstCntW-1:0] CntFirstLast = 4'd12;

	// Header bits ahead of the size field: stereo code, unused, has-size,
	// unused, not-compressed
	localparam logic [22:0] HdrLead = 23'b001_0000_000000000000_1_00_1;

	// Frame footer
	localparam logic [2:0] FooterVal = 3'b111;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_FRAME_SAMPLES    = 2'd0,
		CFG_MONO_MODE        = 2'd1,
		CFG_INPUT_BIG_ENDIAN = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_PAD    = 1'b1
	} op_t;

	typedef struct packed {
		logic [FrameW-1:0] frame_samples;
		logic              mono_mode;
		logic              input_big_endian;
	} cfg_regs_t;

	typedef struct packed {
		logic [CfgIdxW-1:0]  index;
		logic [CfgDataW-1:0] value;
	} cfg_wr_t;

	typedef struct packed {
		op_t              operation;
		logic [WordW-1:0] sample_word;
	} in_item_t;

	typedef struct packed {
		logic [ByteW-1:0] out_byte;
		logic             run_last;
		logic             frame_end;
	} out_item_t;

	typedef struct packed {
		logic [BurstW-1:0]    bytes;
		logic [BurstCntW-1:0] count;
		logic                 frame_end;
	} burst_t;

endpackage

@@ sv/afp_chan_if.sv @@
interface afp_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ sv/afp_frame_ctl.sv @@
module afp_frame_ctl import afp_pkg::*; #(
	parameter int unsigned MAX_FRAME_SAMPLES = 16384
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  in_item_t  item_s1,
	input  cfg_regs_t cfg_regs,
	output burst_t    burst
);

	localparam int unsigned SampW = $clog2(MAX_FRAME_SAMPLES + 1);

	logic             in_frame_q;
	logic [SampW-1:0] done_q;
	logic [PendW-1:0] pend_q;

	logic [WordW-1:0] size_w;
	logic [SampW-1:0] size_eff;
	logic             hdr;
	logic [ByteW-1:0] b0, b1, b2, b3, hi, lo;
	logic [WordW-1:0] data;
	logic [SampW-1:0] done_nx;
	logic             closing;
	logic [PendW-1:0] pend;
	logic [WordW-1:0] dbytes;
	logic [15:0]      foot;

	// Clamp the frame size to the supported range
	always_comb begin
		if (cfg_regs.frame_samples == '0) begin
			size_w = 32'd1;
		end else if (32'(cfg_regs.frame_samples) > 32'(MAX_FRAME_SAMPLES)) begin
			size_w = 32'(MAX_FRAME_SAMPLES);
		end else begin
			size_w = 32'(cfg_regs.frame_samples);
		end
		size_eff = size_w[SampW-1:0];
	end

	// Order sample bytes big endian; mono repeats the one sample, a pad item gives zeros
	always_comb begin
		b0 = item_s1.sample_word[7:0];
		b1 = item_s1.sample_word[15:8];
		b2 = item_s1.sample_word[23:16];
		b3 = item_s1.sample_word[31:24];
		hi = cfg_regs.input_big_endian ? b0 : b1;
		lo = cfg_regs.input_big_endian ? b1 : b0;
		if (item_s1.operation == OP_PAD) begin
			data = '0;
		end else if (cfg_regs.mono_mode) begin
			data = {hi, lo, hi, lo};
		end else if (cfg_regs.input_big_endian) begin
			data = {b0, b1, b2, b3};
		end else begin
			data = {b1, b0, b3, b2};
		end
	end

	// Assemble the byte burst for this item
	always_comb begin
		hdr     = !in_frame_q;
		done_nx = (hdr ? '0 : done_q) + SampW'(1);
		closing = done_nx >= size_eff;
		pend    = hdr ? size_w[PendW-1:0] : pend_q;
		dbytes  = {pend, data[WordW-1:PendW]};
		foot    = {data[PendW-1:0], FooterVal, 6'b0};
		if (hdr) begin
			burst.bytes = {HdrLead, size_w[WordW-1:PendW], dbytes, foot};
			burst.count = closing ? CntFirstLast : CntFirst;
		end else begin
			burst.bytes = {dbytes, foot, 48'b0};
			burst.count = closing ? CntLast : CntMid;
		end
		burst.frame_end = closing;
	end

	// Advance frame state on each loaded item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			done_q     <= '0;
		end else if (load) begin
			in_frame_q <= !closing;
			done_q     <= closing ? '0 : done_nx;
		end
	end

	// Hold the seven bits left in the partial byte
	always_ff @(posedge clk) begin
		if (load) begin
			pend_q <= data[PendW-1:0];
		end
	end

endmodule

@@ sv/afp_byte_out.sv @@
module afp_byte_out import afp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  burst_t burst,
	output logic   buf_free,
	afp_chan_if.source result
);

	logic [BurstW-1:0]    buf_q;
	logic [BurstCntW-1:0] cnt_q;
	logic                 end_q;
	logic                 fire;
	logic                 last;

	assign last     = cnt_q == BurstCntW'(1);
	assign fire     = result.valid && result.ready;
	assign buf_free = (cnt_q == '0) || (fire && last);

	// Present the head byte of the burst
	assign result.valid          = cnt_q != '0;
	assign result.data.out_byte  = buf_q[BurstW-1 -: ByteW];
	assign result.data.run_last  = last;
	assign result.data.frame_end = end_q && last;

	// Count remaining bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= burst.count;
		end else if (fire) begin
			cnt_q <= cnt_q - BurstCntW'(1);
		end
	end

	// Load a new burst or shift out one byte per transaction
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= burst.bytes;
			end_q <= burst.frame_end;
		end else if (fire) begin
			buf_q <= {buf_q[BurstW-ByteW-1:0], {ByteW{1'b0}}};
		end
	end

endmodule

@@ sv/alac_uncompressed_frame_packer_core.sv @@
// Uncompressed ALAC frame packer, 16-bit PCM.
// Channels: item (operation, sample_word) in, result (out_byte, run_last,
// frame_end) out, cfg (index, value) register writes; all valid/ready.
// A transaction on item produces a burst of bytes on result, MSB first:
// 10 bytes for the first item of a frame (header plus sample), 4 for each
// further item, 6 for the item that closes the frame (sample, footer and
// flush), 12 when a one-sample frame opens and closes on the same item.
// run_last marks the last byte of a burst, frame_end the last byte of a frame.
// An item passes the input register, then the burst buffer, before its first
// byte is valid. Throughput is one byte per cycle, set by the result port,
// while the receiver is ready.
// An input register holds the next item while the current burst drains, so
// bursts follow each other without a gap.
// When the receiver stalls, the head byte holds, then the input register
// fills and item.ready drops until the burst buffer frees.
// cfg is always ready; writes take effect on the next item.
// Reset empties both registers, reopens with a header on the next item and
// restores frame_samples 352, stereo, little-endian input.
module alac_uncompressed_frame_packer_core import afp_pkg::*; #(
	parameter int unsigned MAX_FRAME_SAMPLES = 16384
) (
	input  logic clk,
	input  logic arst_n,
	afp_chan_if.sink   item,
	afp_chan_if.source result,
	afp_chan_if.sink   cfg
);

	cfg_regs_t cfg_q;
	in_item_t  item_s1;
	logic      valid_s1;
	logic      load;
	logic      buf_free;
	burst_t    burst;

	// Register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_samples    <= FrameW'(352);
			cfg_q.mono_mode        <= 1'b0;
			cfg_q.input_big_endian <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				CFG_FRAME_SAMPLES:    cfg_q.frame_samples    <= cfg.data.value;
				CFG_MONO_MODE:        cfg_q.mono_mode        <= cfg.data.value[0];
				CFG_INPUT_BIG_ENDIAN: cfg_q.input_big_endian <= cfg.data.value[0];
				default: ;
			endcase
		end
	end

	// Input register: hand over when the burst buffer frees
	assign load       = valid_s1 && buf_free;
	assign item.ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	afp_frame_ctl #(
		.MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)
	) u_frame_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.item_s1  (item_s1),
		.cfg_regs (cfg_q),
		.burst    (burst)
	);

	afp_byte_out u_byte_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.burst    (burst),
		.buf_free (buf_free),
		.result   (result)
	);

endmodule

@@ sv/afp_checker.sv @@
module afp_checker import afp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      result_valid,
	input logic      result_ready,
	input out_item_t result_data
);

	// Hold a stalled byte
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result changed while stalled");

	// Close a frame only on the last byte of a burst
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.frame_end |-> result_data.run_last)
		else $error("frame_end without run_last");

	// Drain a burst without gaps
	a_burst_contig: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result_data.run_last |=> result_valid)
		else $error("gap inside a burst");

	// Drop output during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid during reset");

endmodule

bind alac_uncompressed_frame_packer_core afp_checker u_afp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);
